// ===== sv/rqt_pkg.sv =====
// ----------------------------------------------------------------------------
// rqt_pkg
// Shared types, codes and default sizes of the request queue with timeout.
// ----------------------------------------------------------------------------
`default_nettype none

package rqt_pkg;

  localparam int POOL_BYTES_DEF    = 256;
  localparam int QUEUE_DEPTH_DEF   = 8;
  localparam int MAX_REQ_BYTES_DEF = 64;

  localparam logic [15:0] STARTUP_DELAY_RST   = 16'd1000;
  localparam logic [15:0] DEFAULT_TIMEOUT_RST = 16'd100;

  localparam logic CFG_STARTUP_DELAY   = 1'b0;
  localparam logic CFG_DEFAULT_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    CMD_HEADER   = 2'd0,
    CMD_BYTE     = 2'd1,
    CMD_TICK     = 2'd2,
    CMD_RESPONSE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    K_ADD     = 3'd0,
    K_SENT    = 3'd1,
    K_REPLY   = 3'd2,
    K_TIMEOUT = 3'd3,
    K_ERROR   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_QUEUE_FULL = 3'd2,
    ST_POOL_FULL  = 3'd3,
    ST_TOO_LONG   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    SEQ_STARTUP = 2'd0,
    SEQ_IDLE    = 2'd1,
    SEQ_WAIT    = 2'd2
  } seq_t;

  typedef enum logic [2:0] {
    C_ACCEPT = 3'd0,
    C_EXEC   = 3'd1,
    C_DESC   = 3'd2,
    C_BREAD  = 3'd3,
    C_BEMIT  = 3'd4
  } ctl_t;

endpackage

`default_nettype wire

// ===== sv/rqt_ram.sv =====
// ----------------------------------------------------------------------------
// rqt_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rqt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/request_queue_with_timeout.sv =====
// ----------------------------------------------------------------------------
// request_queue_with_timeout
// Queues request lines with tag and reply timeout, sends them one at a time
// and waits for a reply or a timeout.
// ----------------------------------------------------------------------------
// An item is taken in C_ACCEPT and executed in C_EXEC, where an item with a
// result stays while the result register has not drained. A tick that
// starts a request then reads the descriptor in C_DESC and, for each request
// byte, reads the byte pool in C_BREAD and sends the byte in C_BEMIT, which
// waits for the result register too; the byte pool port has registered data.
// Descriptors and bytes live in two memories; only committed entries are
// read, so neither memory needs clearing after reset. Accesses never overlap
// because one item is worked at a time.
`default_nettype none

module request_queue_with_timeout
  import rqt_pkg::*;
#(
  parameter int POOL_BYTES    = POOL_BYTES_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  parameter int MAX_REQ_BYTES = MAX_REQ_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  req_len,
  input  wire logic [31:0] timeout_ticks,
  input  wire logic [7:0]  request_id,
  input  wire logic [7:0]  data_byte,
  input  wire logic [7:0]  tick_amount,
  input  wire logic [15:0] line_tag,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [2:0]       kind,
  output logic [2:0]       status,
  output logic [7:0]       out_byte,
  output logic [7:0]       out_id,
  output logic [15:0]      out_line_tag,
  output logic             last
);

  localparam int PA_W  = $clog2(POOL_BYTES);
  localparam int PC_W  = $clog2(POOL_BYTES + 1);
  localparam int QA_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int LEN_W = $clog2(MAX_REQ_BYTES);
  localparam int DW    = LEN_W + 40;
  localparam int CW    = (PC_W > 8) ? PC_W : 8;

  // configuration
  logic [15:0] startup_delay;
  logic [15:0] default_timeout;

  // control
  ctl_t state, state_next;
  seq_t seq;

  // item registers
  cmd_t        it_cmd;
  logic [7:0]  it_len;
  logic [31:0] it_tmo;
  logic [7:0]  it_id;
  logic [7:0]  it_byte;
  logic [7:0]  it_tick;
  logic [15:0] it_tag;

  // queue and pool bookkeeping
  logic [QA_W-1:0]  q_rd, q_wr, q_rd_inc, q_wr_inc;
  logic [QC_W-1:0]  q_cnt;
  logic [PA_W-1:0]  p_rd, p_wr, fill_ptr, p_rd_inc, fill_inc;
  logic [PC_W-1:0]  p_cnt;
  logic [LEN_W-1:0] pending;
  logic [LEN_W-1:0] stage_len;
  logic [31:0]      stage_tmo;
  logic [7:0]       stage_id;

  // sequencing
  logic [31:0]      tick_counter, tick_next;
  logic [32:0]      tick_sum;
  logic [31:0]      current_timeout;
  logic [7:0]       current_id;
  logic [LEN_W-1:0] remaining;

  // memories
  logic             pool_we, pool_re, desc_we, desc_re;
  logic [7:0]       pool_rdata;
  logic [DW-1:0]    desc_wdata, desc_rdata;
  logic [LEN_W-1:0] d_len;
  logic [31:0]      d_tmo;
  logic [7:0]       d_id;

  // result register
  kind_t   res_kind;
  status_t res_status;
  logic [7:0]  res_byte, res_id;
  logic [15:0] res_tag;
  logic        res_last;
  logic        out_free, out_load;
  kind_t       o_kind;
  status_t     o_status;
  logic [7:0]  o_byte, o_id;
  logic [15:0] o_tag;
  logic        o_last;

  status_t     hdr_status;
  logic [CW-1:0] pool_free;
  logic        exec_done;

  rqt_ram #(.WIDTH(8), .DEPTH(POOL_BYTES), .AW(PA_W)) u_pool (
    .clk   (clk),
    .we    (pool_we),
    .waddr (fill_ptr),
    .wdata (it_byte),
    .re    (pool_re),
    .raddr (p_rd),
    .rdata (pool_rdata)
  );

  rqt_ram #(.WIDTH(DW), .DEPTH(QUEUE_DEPTH), .AW(QA_W)) u_desc (
    .clk   (clk),
    .we    (desc_we),
    .waddr (q_wr),
    .wdata (desc_wdata),
    .re    (desc_re),
    .raddr (q_rd),
    .rdata (desc_rdata)
  );

  assign desc_wdata = {stage_len, stage_tmo, stage_id};
  assign d_len      = desc_rdata[DW-1 -: LEN_W];
  assign d_tmo      = desc_rdata[39:8];
  assign d_id       = desc_rdata[7:0];

  assign item_stall = (state != C_ACCEPT);
  assign out_free   = !result_valid || !result_stall;
  assign exec_done  = (state == C_EXEC) && (state_next != C_EXEC);

  assign q_rd_inc = (q_rd == QA_W'(QUEUE_DEPTH - 1)) ? '0 : q_rd + 1'b1;
  assign q_wr_inc = (q_wr == QA_W'(QUEUE_DEPTH - 1)) ? '0 : q_wr + 1'b1;
  assign p_rd_inc = (p_rd == PA_W'(POOL_BYTES - 1)) ? '0 : p_rd + 1'b1;
  assign fill_inc = (fill_ptr == PA_W'(POOL_BYTES - 1)) ? '0 : fill_ptr + 1'b1;

  assign tick_sum  = {1'b0, tick_counter} + 33'(it_tick);
  assign tick_next = tick_sum[32] ? '1 : tick_sum[31:0];

  assign pool_free = CW'(POOL_BYTES) - CW'(p_cnt);

  always_comb begin
    if (it_len == 8'd0) begin
      hdr_status = ST_EMPTY;
    end else if (q_cnt == QC_W'(QUEUE_DEPTH)) begin
      hdr_status = ST_QUEUE_FULL;
    end else if (CW'(it_len) > pool_free) begin
      hdr_status = ST_POOL_FULL;
    end else if ({1'b0, it_len} > 9'(MAX_REQ_BYTES - 1)) begin
      hdr_status = ST_TOO_LONG;
    end else begin
      hdr_status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_ACCEPT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    o_kind     = K_ADD;
    o_status   = ST_OK;
    o_byte     = '0;
    o_id       = '0;
    o_tag      = '0;
    o_last     = 1'b0;
    pool_we    = 1'b0;
    pool_re    = 1'b0;
    desc_we    = 1'b0;
    desc_re    = 1'b0;
    unique case (state)
      C_ACCEPT: begin
        if (item_valid) begin
          state_next = C_EXEC;
        end
      end
      C_EXEC: begin
        case (it_cmd)
          CMD_HEADER: begin
            if (out_free) begin
              out_load   = 1'b1;
              o_kind     = K_ADD;
              o_status   = hdr_status;
              o_id       = it_id;
              state_next = C_ACCEPT;
            end
          end
          CMD_BYTE: begin
            pool_we    = (pending != '0);
            desc_we    = (pending == LEN_W'(1));
            state_next = C_ACCEPT;
          end
          CMD_TICK: begin
            case (seq)
              SEQ_STARTUP: state_next = C_ACCEPT;
              SEQ_WAIT: begin
                if (tick_next >= current_timeout) begin
                  if (out_free) begin
                    out_load   = 1'b1;
                    o_kind     = K_TIMEOUT;
                    o_id       = current_id;
                    state_next = C_ACCEPT;
                  end
                end else begin
                  state_next = C_ACCEPT;
                end
              end
              default: begin
                if (q_cnt != '0) begin
                  desc_re    = 1'b1;
                  state_next = C_DESC;
                end else begin
                  state_next = C_ACCEPT;
                end
              end
            endcase
          end
          default: begin
            if (out_free) begin
              out_load   = 1'b1;
              state_next = C_ACCEPT;
              if (seq == SEQ_WAIT) begin
                o_kind = K_REPLY;
                o_id   = current_id;
                o_tag  = it_tag;
              end else begin
                o_kind = K_ERROR;
              end
            end
          end
        endcase
      end
      C_DESC: state_next = C_BREAD;
      C_BREAD: begin
        pool_re    = 1'b1;
        state_next = C_BEMIT;
      end
      C_BEMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          o_kind     = K_SENT;
          o_byte     = pool_rdata;
          o_id       = current_id;
          o_last     = (remaining == LEN_W'(1));
          state_next = (remaining == LEN_W'(1)) ? C_ACCEPT : C_BREAD;
        end
      end
      default: state_next = C_ACCEPT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      startup_delay   <= STARTUP_DELAY_RST;
      default_timeout <= DEFAULT_TIMEOUT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_STARTUP_DELAY:   startup_delay   <= cfg_data;
        CFG_DEFAULT_TIMEOUT: default_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == C_ACCEPT && item_valid) begin
      it_cmd  <= cmd_t'(cmd);
      it_len  <= req_len;
      it_tmo  <= timeout_ticks;
      it_id   <= request_id;
      it_byte <= data_byte;
      it_tick <= tick_amount;
      it_tag  <= line_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done && it_cmd == CMD_HEADER && hdr_status == ST_OK) begin
      stage_len <= LEN_W'(it_len);
      stage_tmo <= it_tmo;
      stage_id  <= it_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_rd            <= '0;
      q_wr            <= '0;
      q_cnt           <= '0;
      p_rd            <= '0;
      p_wr            <= '0;
      p_cnt           <= '0;
      fill_ptr        <= '0;
      pending         <= '0;
      seq             <= SEQ_STARTUP;
      tick_counter    <= '0;
      current_timeout <= '0;
      current_id      <= '0;
      remaining       <= '0;
    end else begin
      if (exec_done) begin
        case (it_cmd)
          CMD_HEADER: begin
            pending <= (hdr_status == ST_OK) ? LEN_W'(it_len) : '0;
            if (hdr_status == ST_OK) begin
              fill_ptr <= p_wr;
            end
          end
          CMD_BYTE: begin
            if (pending != '0) begin
              fill_ptr <= fill_inc;
              pending  <= pending - 1'b1;
              if (pending == LEN_W'(1)) begin
                p_wr  <= fill_inc;
                p_cnt <= p_cnt + PC_W'(stage_len);
                q_wr  <= q_wr_inc;
                q_cnt <= q_cnt + 1'b1;
              end
            end
          end
          CMD_TICK: begin
            tick_counter <= tick_next;
            if (seq == SEQ_STARTUP) begin
              if (tick_next >= 32'(startup_delay)) begin
                seq <= SEQ_IDLE;
              end
            end else if (seq == SEQ_WAIT) begin
              if (tick_next >= current_timeout) begin
                seq <= SEQ_IDLE;
              end
            end
          end
          default: begin
            if (seq == SEQ_WAIT) begin
              seq <= SEQ_IDLE;
            end
          end
        endcase
      end
      if (state == C_DESC) begin
        remaining       <= d_len;
        current_id      <= d_id;
        current_timeout <= (d_tmo != '0) ? d_tmo : 32'(default_timeout);
        tick_counter    <= '0;
        seq             <= SEQ_WAIT;
        q_rd            <= q_rd_inc;
        q_cnt           <= q_cnt - 1'b1;
        p_cnt           <= p_cnt - PC_W'(d_len);
      end
      if (state == C_BEMIT && out_load) begin
        p_rd      <= p_rd_inc;
        remaining <= remaining - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_kind   <= o_kind;
      res_status <= o_status;
      res_byte   <= o_byte;
      res_id     <= o_id;
      res_tag    <= o_tag;
      res_last   <= o_last;
    end
  end

  assign kind         = res_kind;
  assign status       = res_status;
  assign out_byte     = res_byte;
  assign out_id       = res_id;
  assign out_line_tag = res_tag;
  assign last         = res_last;

  a_qcnt_bound: assert property (@(posedge clk) disable iff (rst)
    q_cnt <= QC_W'(QUEUE_DEPTH))
    else $error("descriptor count above queue depth");

  a_pcnt_bound: assert property (@(posedge clk) disable iff (rst)
    p_cnt <= PC_W'(POOL_BYTES))
    else $error("pool count above pool size");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == C_DESC |-> q_cnt != '0)
    else $error("descriptor popped from empty queue");

  a_send_waits: assert property (@(posedge clk) disable iff (rst)
    state == C_BEMIT |-> seq == SEQ_WAIT && remaining != '0)
    else $error("byte sent outside a request");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !result_valid || !result_stall)
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

// ===== dv/request_queue_with_timeout_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// request_queue_with_timeout_tb
// Drives header, byte, tick and response transfers into the request queue,
// predicts every add status, sent byte, reply, timeout and error event from
// a behavioral copy of the queue, and checks each result transfer in order
// under random gaps, random stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------

module request_queue_with_timeout_tb;
  import rqt_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;

  typedef struct {
    logic [7:0]  len;
    logic [31:0] tmo;
    logic [7:0]  id;
  } req_desc_t;

  typedef struct {
    kind_t       kind;
    status_t     status;
    logic [7:0]  data;
    logic [7:0]  id;
    logic [15:0] tag;
    logic        last;
  } req_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [1:0]  cmd = '0;
  logic [7:0]  req_len = '0;
  logic [31:0] timeout_ticks = '0;
  logic [7:0]  request_id = '0;
  logic [7:0]  data_byte = '0;
  logic [7:0]  tick_amount = '0;
  logic [15:0] line_tag = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [2:0]  kind;
  logic [2:0]  status;
  logic [7:0]  out_byte;
  logic [7:0]  out_id;
  logic [15:0] out_line_tag;
  logic        last;

  request_queue_with_timeout dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .cmd          (cmd),
    .req_len      (req_len),
    .timeout_ticks(timeout_ticks),
    .request_id   (request_id),
    .data_byte    (data_byte),
    .tick_amount  (tick_amount),
    .line_tag     (line_tag),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .status       (status),
    .out_byte     (out_byte),
    .out_id       (out_id),
    .out_line_tag (out_line_tag),
    .last         (last)
  );

  always #10 clk = ~clk;

  // Request queue state as predicted
  req_desc_t   desc_mem [QUEUE_DEPTH_DEF];
  logic [7:0]  pool_mem [POOL_BYTES_DEF];
  int unsigned dq_rd = 0, dq_wr = 0, dq_cnt = 0;
  int unsigned pool_rd = 0, pool_wr = 0, pool_cnt = 0;
  int unsigned fill_left = 0, fill_cnt = 0;
  req_desc_t   staged;
  seq_t        seq = SEQ_STARTUP;
  logic [31:0] tick_cnt = '0;
  logic [31:0] cur_tmo = '0;
  logic [7:0]  cur_id = '0;
  logic [15:0] startup_cfg = STARTUP_DELAY_RST;
  logic [15:0] dflt_cfg = DEFAULT_TIMEOUT_RST;

  req_event_t  due_events [$];
  int          failures = 0;
  int unsigned sent_items = 0;
  bit          offering = 1'b0;
  int unsigned gap_pending = 0;
  bit          quiet = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned holds_taken = 0;
  int          hold_left = 0;
  int unsigned stall_run = 0;

  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void expect_event(kind_t k, status_t s, logic [7:0] d, logic [7:0] id,
                                       logic [15:0] tg, logic lst);
    req_event_t e;
    e.kind = k;
    e.status = s;
    e.data = d;
    e.id = id;
    e.tag = tg;
    e.last = lst;
    due_events.push_back(e);
  endfunction

  function automatic void update_request_model(cmd_t c, logic [7:0] ln, logic [31:0] tmo,
                                               logic [7:0] id, logic [7:0] dat,
                                               logic [7:0] amt, logic [15:0] tg);
    status_t   st;
    req_desc_t d;
    int        i;
    case (c)
      CMD_HEADER: begin
        fill_left = 0;
        fill_cnt = 0;
        if (ln == 0) st = ST_EMPTY;
        else if (dq_cnt >= QUEUE_DEPTH_DEF) st = ST_QUEUE_FULL;
        else if (32'(ln) > POOL_BYTES_DEF - pool_cnt) st = ST_POOL_FULL;
        else if (32'(ln) > MAX_REQ_BYTES_DEF - 1) st = ST_TOO_LONG;
        else begin
          st = ST_OK;
          staged.len = ln;
          staged.tmo = tmo;
          staged.id = id;
          fill_left = 32'(ln);
        end
        expect_event(K_ADD, st, 8'd0, id, 16'd0, 1'b0);
      end
      CMD_BYTE: begin
        if (fill_left > 0) begin
          pool_mem[(pool_wr + fill_cnt) % POOL_BYTES_DEF] = dat;
          fill_cnt++;
          fill_left--;
          if (fill_left == 0) begin
            pool_wr = (pool_wr + 32'(staged.len)) % POOL_BYTES_DEF;
            pool_cnt += 32'(staged.len);
            desc_mem[dq_wr] = staged;
            dq_wr = (dq_wr + 1) % QUEUE_DEPTH_DEF;
            dq_cnt++;
            fill_cnt = 0;
          end
        end
      end
      CMD_TICK: begin
        if (tick_cnt > 32'hFFFF_FFFF - 32'(amt)) tick_cnt = '1;
        else tick_cnt += 32'(amt);
        case (seq)
          SEQ_STARTUP: begin
            if (tick_cnt >= 32'(startup_cfg)) seq = SEQ_IDLE;
          end
          SEQ_WAIT: begin
            if (tick_cnt >= cur_tmo) begin
              expect_event(K_TIMEOUT, ST_OK, 8'd0, cur_id, 16'd0, 1'b0);
              seq = SEQ_IDLE;
            end
          end
          default: begin
            if (dq_cnt > 0) begin
              d = desc_mem[dq_rd];
              dq_rd = (dq_rd + 1) % QUEUE_DEPTH_DEF;
              dq_cnt--;
              for (i = 0; i < int'(d.len); i++) begin
                expect_event(K_SENT, ST_OK, pool_mem[pool_rd], d.id, 16'd0,
                             i == int'(d.len) - 1);
                pool_rd = (pool_rd + 1) % POOL_BYTES_DEF;
              end
              pool_cnt -= 32'(d.len);
              cur_id = d.id;
              cur_tmo = (d.tmo != 0) ? d.tmo : 32'(dflt_cfg);
              tick_cnt = '0;
              seq = SEQ_WAIT;
            end
          end
        endcase
      end
      CMD_RESPONSE: begin
        if (seq != SEQ_WAIT) begin
          expect_event(K_ERROR, ST_OK, 8'd0, 8'd0, 16'd0, 1'b0);
        end else begin
          expect_event(K_REPLY, ST_OK, 8'd0, cur_id, tg, 1'b0);
          seq = SEQ_IDLE;
        end
      end
    endcase
  endfunction

  task automatic send_item(cmd_t c, logic [7:0] ln, logic [31:0] tmo, logic [7:0] id,
                           logic [7:0] dat, logic [7:0] amt, logic [15:0] tg);
    if (!offering) repeat (gap_pending) @(posedge clk);
    item_valid <= 1'b1;
    cmd <= c;
    req_len <= ln;
    timeout_ticks <= tmo;
    request_id <= id;
    data_byte <= dat;
    tick_amount <= amt;
    line_tag <= tg;
    offering = 1'b1;
    do @(posedge clk); while (item_stall !== 1'b0);
    if (c != CMD_BYTE || fill_left > 0) sent_items++;
    update_request_model(c, ln, tmo, id, dat, amt, tg);
    gap_pending = idle_gap();
    if (gap_pending > 0) begin
      item_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic idle_input();
    if (offering) begin
      item_valid <= 1'b0;
      offering = 1'b0;
    end
    if (gap_pending == 0) gap_pending = 1;
  endtask

  task automatic send_header(logic [7:0] ln, logic [31:0] tmo, logic [7:0] id);
    send_item(CMD_HEADER, ln, tmo, id, 8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic send_byte(logic [7:0] dat);
    send_item(CMD_BYTE, 8'($urandom), $urandom, 8'($urandom), dat, 8'($urandom),
              16'($urandom));
  endtask

  task automatic send_tick(logic [7:0] amt);
    send_item(CMD_TICK, 8'($urandom), $urandom, 8'($urandom), 8'($urandom), amt,
              16'($urandom));
  endtask

  task automatic send_response(logic [15:0] tg);
    send_item(CMD_RESPONSE, 8'($urandom), $urandom, 8'($urandom), 8'($urandom),
              8'($urandom), tg);
  endtask

  task automatic send_request(int ln, logic [31:0] tmo, logic [7:0] id);
    int i;
    send_header(8'(ln), tmo, id);
    for (i = 0; i < ln; i++) send_byte(8'($urandom));
  endtask

  task automatic wait_for_idle();
    idle_input();
    while (due_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic idx, logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_STARTUP_DELAY) startup_cfg = val;
    else dflt_cfg = val;
    @(posedge clk);
  endtask

  function automatic int rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 62);
    return 63;
  endfunction

  function automatic logic [31:0] rand_timeout();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return 32'd0;
    if (r < 80) return $urandom_range(1, 600);
    return $urandom;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h actual %0h", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    req_event_t want;
    if (!rst && result_valid === 1'b1 && result_stall == 1'b0) begin
      if (due_events.size() == 0) begin
        $error("unexpected result transfer: kind %0d id %0h", kind, out_id);
        failures++;
      end else begin
        want = due_events.pop_front();
        check_field("kind", 32'(want.kind), 32'(kind));
        check_field("status", 32'(want.status), 32'(status));
        check_field("out_byte", 32'(want.data), 32'(out_byte));
        check_field("out_id", 32'(want.id), 32'(out_id));
        check_field("out_line_tag", 32'(want.tag), 32'(out_line_tag));
        check_field("last", 32'(want.last), 32'(last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_left = 0;
      stall_run = 0;
    end else if (holds_taken != hold_requests || hold_left > 0) begin
      if (holds_taken != hold_requests) begin
        hold_left = HOLD_CYCLES;
        holds_taken = hold_requests;
      end
      result_stall <= 1'b1;
      hold_left--;
    end else if (stall_run > 0) begin
      result_stall <= 1'b1;
      stall_run--;
    end else begin
      stall_run = idle_gap();
      result_stall <= (stall_run > 0);
      if (stall_run > 0) stall_run--;
    end
  end

  task automatic test_directed();
    send_response(16'h1234);
    send_header(8'd0, 32'd0, 8'hFF);
    send_header(8'd2, 32'd0, 8'h11);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_header(8'd255, 32'd1, 8'h22);
    send_header(8'd64, 32'd5, 8'h00);
    send_header(8'd63, 32'hFFFF_FFFF, 8'h33);
    send_byte(8'h5A);
    send_byte(8'hA5);
    send_header(8'd1, 32'd3, 8'h44);
    send_byte(8'hC3);
    send_byte(8'h77);
    send_tick(8'd255);
    send_tick(8'd255);
    send_tick(8'd255);
    send_response(16'h0000);
    wait_for_idle();
    write_register(CFG_STARTUP_DELAY, 16'd800);
    send_tick(8'd34);
    send_tick(8'd1);
    send_tick(8'd0);
    send_response(16'hFFFF);
    send_response(16'hABCD);
    send_tick(8'd0);
    send_tick(8'd2);
    send_tick(8'd1);
    send_tick(8'd255);
  endtask

  task automatic test_backpressure();
    int i;
    wait_for_idle();
    quiet = 1'b1;
    hold_requests++;
    send_request(63, 32'd50, 8'hA0);
    for (i = 0; i < 7; i++) begin
      send_request($urandom_range(1, 4), $urandom_range(1, 200), 8'($urandom));
    end
    send_header(8'd1, 32'd0, 8'hEE);
    send_tick(8'd0);
    quiet = 1'b0;
    wait_for_idle();
  endtask

  task automatic test_random_traffic(logic [15:0] dflt, logic [15:0] startup,
                                     int unsigned n_quiet, int unsigned n_items);
    int unsigned base;
    int          r, ln, k, i;
    wait_for_idle();
    write_register(CFG_DEFAULT_TIMEOUT, dflt);
    write_register(CFG_STARTUP_DELAY, startup);
    base = sent_items;
    while (sent_items - base < n_items) begin
      quiet = (sent_items - base < n_quiet);
      r = $urandom_range(0, 99);
      if (r < 40) begin
        send_request(rand_len(), rand_timeout(), 8'($urandom));
      end else if (r < 68) begin
        send_tick($urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                       : 8'($urandom_range(0, 255)));
      end else if (r < 80) begin
        send_response(16'($urandom));
      end else if (r < 88) begin
        send_header(8'($urandom_range(0, 255)), $urandom, 8'($urandom));
      end else if (r < 93) begin
        send_byte(8'($urandom));
      end else begin
        // drop a partly filled request
        ln = rand_len();
        send_header(8'(ln), rand_timeout(), 8'($urandom));
        k = $urandom_range(0, ln - 1);
        for (i = 0; i < k; i++) send_byte(8'($urandom));
      end
    end
    quiet = 1'b0;
  endtask

  initial begin : main
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random_traffic(16'd1, 16'd0, 0, 90);
    test_random_traffic(16'hFFFF, 16'hFFFF, 40, 95);
    test_random_traffic(16'($urandom_range(1, 65535)), 16'($urandom), 0, 90);
    wait_for_idle();
    if (failures == 0) begin
      $display("request_queue_with_timeout verification clean");
    end else begin
      $display("request_queue_with_timeout verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(200_000_000);
    $display("request_queue_with_timeout verification failed");
    $finish;
  end

endmodule
